// ===== rtl/tpbc_pkg.sv =====
`default_nettype none

package tpbc_pkg;

	// character class codes
	localparam logic [1:0] KIND_NEWLINE = 2'd0;
	localparam logic [1:0] KIND_BLANK   = 2'd1;

	// configuration register indexes
	localparam logic [1:0] REG_MAX_LINE_WIDTH     = 2'd0;
	localparam logic [1:0] REG_MAX_CONTENT_HEIGHT = 2'd1;
	localparam logic [1:0] REG_LINE_HEIGHT        = 2'd2;
	localparam logic [1:0] REG_PARAGRAPH_GAP      = 2'd3;

	localparam logic [15:0] MAX16 = 16'hFFFF;
	localparam logic [23:0] MAX24 = 24'hFF_FFFF;

	typedef struct packed {
		logic [23:0] max_line_width;
		logic [23:0] max_content_height;
		logic [21:0] row_height;
		logic [21:0] paragraph_gap;
	} cfg_t;

	typedef struct packed {
		logic [15:0] page_total;
		logic [23:0] used_height;
		logic [23:0] line_width_sum;
		logic [23:0] word_width_sum;
		logic [15:0] paragraph_lines;
		logic        carry_paragraph;
	} state_t;

	// clamp a grown sum to 24 bits
	function automatic logic [23:0] sat24(input logic [25:0] v);
		logic [23:0] r;
		r = (v[25:24] != 2'b00) ? MAX24 : v[23:0];
		return r;
	endfunction

	// saturating 16 bit increment
	function automatic logic [15:0] inc16(input logic [15:0] v);
		logic [15:0] r;
		r = (v == MAX16) ? MAX16 : v + 16'd1;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/tpbc_cfg_regs.sv =====
`default_nettype none

module tpbc_cfg_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_en,
	input  wire logic [1:0]   wr_index,
	input  wire logic [23:0]  wr_data,
	output tpbc_pkg::cfg_t    cfg,
	output logic              lh_wr
);

	tpbc_pkg::cfg_t cfg_q;

	// register file, one write per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				tpbc_pkg::REG_MAX_LINE_WIDTH:     cfg_q.max_line_width <= wr_data;
				tpbc_pkg::REG_MAX_CONTENT_HEIGHT: cfg_q.max_content_height <= wr_data;
				tpbc_pkg::REG_LINE_HEIGHT:        cfg_q.row_height <= wr_data[21:0];
				tpbc_pkg::REG_PARAGRAPH_GAP:      cfg_q.paragraph_gap <= wr_data[21:0];
				default: ;
			endcase
		end
	end

	assign cfg   = cfg_q;
	assign lh_wr = wr_en && (wr_index == tpbc_pkg::REG_LINE_HEIGHT);

endmodule

`default_nettype wire

// ===== rtl/tpbc_step.sv =====
`default_nettype none

module tpbc_step (
	input  wire tpbc_pkg::cfg_t   cfg,
	input  wire tpbc_pkg::state_t cur,
	input  wire logic [1:0]       char_kind,
	input  wire logic [15:0]      glyph_w,
	output tpbc_pkg::state_t      nxt
);

	logic [23:0] lh2;
	logic [23:0] lh3;
	logic [23:0] nl_height;
	logic [23:0] wrap_height;
	logic [23:0] new_word;
	logic [23:0] new_line;
	logic [15:0] new_lines;

	// multiples of the line height
	assign lh2 = {1'b0, cfg.row_height, 1'b0};
	assign lh3 = lh2 + {2'b00, cfg.row_height};

	// height sums for newline and wrap
	assign nl_height = tpbc_pkg::sat24({2'b00, cur.used_height}
		+ {4'h0, cfg.paragraph_gap} + {4'h0, cfg.row_height});
	assign wrap_height = tpbc_pkg::sat24({2'b00, cur.used_height}
		+ {4'h0, cfg.row_height});

	// word and line width after this character
	assign new_word = (char_kind == tpbc_pkg::KIND_BLANK) ? 24'd0 :
		tpbc_pkg::sat24({2'b00, cur.word_width_sum} + {10'd0, glyph_w});
	assign new_line = tpbc_pkg::sat24({2'b00, cur.line_width_sum} + {10'd0, glyph_w});
	assign new_lines = tpbc_pkg::inc16(cur.paragraph_lines);

	always_comb begin
		nxt = cur;
		if (char_kind == tpbc_pkg::KIND_NEWLINE) begin
			nxt.paragraph_lines = 16'd1;
			nxt.word_width_sum  = '0;
			nxt.line_width_sum  = '0;
			nxt.carry_paragraph = 1'b0;
			if (nl_height >= cfg.max_content_height) begin
				nxt.page_total  = tpbc_pkg::inc16(cur.page_total);
				nxt.used_height = {2'b00, cfg.row_height};
			end else begin
				nxt.used_height = nl_height;
			end
		end else begin
			nxt.word_width_sum = new_word;
			nxt.line_width_sum = new_line;
			// wrap: partial word moves to the next line
			if (new_line >= cfg.max_line_width) begin
				nxt.line_width_sum  = new_word;
				nxt.paragraph_lines = new_lines;
				if (cur.carry_paragraph && new_lines == 16'd4) begin
					nxt.used_height = lh2;
				end else if (wrap_height >= cfg.max_content_height) begin
					nxt.page_total      = tpbc_pkg::inc16(cur.page_total);
					nxt.carry_paragraph = 1'b1;
					case (new_lines)
						16'd1:   nxt.used_height = {2'b00, cfg.row_height};
						16'd3:   nxt.used_height = lh3;
						default: nxt.used_height = lh2;
					endcase
				end else begin
					nxt.used_height = wrap_height;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/text_page_break_counter_top.sv =====
`default_nettype none

// channel  direction  signals                                    fields
// s_*      in         s_tvalid s_tready s_tdata s_tuser          glyph width, char_kind
// m_*      out        m_tvalid m_tready m_tdata                  pages, page_fill
// cfg_*    in         cfg_valid cfg_ready cfg_index cfg_data     register index and data
//
// one character per cycle unless the output stalls; input, then result register
// the rate is set by the state update in the combinational step logic
// reset: page count 1, used height 0, paragraph lines 1, config registers 0
// the input register holds one word while the result register is stalled
// cfg_ready is always high; a line height write before the first word loads used height

module text_page_break_counter_top (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [15:0]  s_tdata,   // [15:0] glyph width
	input  wire logic [1:0]   s_tuser,   // [1:0] char_kind
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [39:0]       m_tdata,   // [15:0] pages, [39:16] page_fill
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [23:0]  cfg_data
);

	tpbc_pkg::cfg_t   cfg;
	tpbc_pkg::state_t st_q;
	tpbc_pkg::state_t st_nxt;
	logic             lh_wr;
	logic             started_q;
	logic             valid_s1;
	logic [1:0]       kind_s1;
	logic [15:0]      width_s1;
	logic             out_valid_q;
	logic [15:0]      out_pages_q;
	logic [23:0]      out_fill_q;
	logic             advance;
	logic             s_fire;

	assign cfg_ready = 1'b1;

	tpbc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg),
		.lh_wr    (lh_wr)
	);

	tpbc_step u_step (
		.cfg        (cfg),
		.cur        (st_q),
		.char_kind  (kind_s1),
		.glyph_w    (width_s1),
		.nxt        (st_nxt)
	);

	// handshake between stages
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_fire   = s_tvalid && s_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			kind_s1  <= s_tuser;
			width_s1 <= s_tdata;
		end
	end

	// running page state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.page_total      <= 16'd1;
			st_q.used_height     <= '0;
			st_q.line_width_sum  <= '0;
			st_q.word_width_sum  <= '0;
			st_q.paragraph_lines <= 16'd1;
			st_q.carry_paragraph <= 1'b0;
			started_q            <= 1'b0;
		end else if (advance) begin
			st_q      <= st_nxt;
			started_q <= 1'b1;
		end else if (lh_wr && !started_q) begin
			st_q.used_height <= {2'b00, cfg_data[21:0]};
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_pages_q <= st_nxt.page_total;
			out_fill_q  <= st_nxt.used_height;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_fill_q, out_pages_q};

	// checks
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("result word missing after state update");

	a_pages_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.page_total != 16'd0 && st_q.paragraph_lines != 16'd0)
		else $error("page or paragraph line count reached zero");

	a_pages_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_pages_q >= $past(st_q.page_total))
		else $error("page count went backward");

	a_lh_preload: assert property (@(posedge clk) disable iff (!arst_n)
		(lh_wr && !started_q && !advance) |=>
			st_q.used_height == {2'b00, $past(cfg_data[21:0])})
		else $error("line height not loaded into used height before start");

	a_input_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1 && $stable(kind_s1) && $stable(width_s1))
		else $error("stalled input register lost its word");

endmodule

`default_nettype wire
